@@ rtl/nwo_pkg.sv @@
// Package for the note waveform oscillator: field widths, fixed-point constants,
// shape and register codes, the sequencer state type and the quarter-wave sine table.
// Depends on nothing; every other file of the block imports it.
package nwo_pkg;

    // Widths of the request, result and configuration fields.
    localparam int FRAME_W    = 31;
    localparam int STEP_W     = 32;
    localparam int SHAPE_W    = 3;
    localparam int AMP_W      = 18;
    localparam int AMP_MAG_W  = AMP_W - 1;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W - 1;
    localparam int AMP_ACC_W  = AMP_MAG_W + MAG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Design constants.
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int AMP_FRAC_BITS  = 16;

    localparam int FULL_SCALE  = 32767;
    localparam int DONE_WINDOW = 328;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Phase bits below the phase resolution are cleared.
    localparam int PHASE_CLR = (PHASE_BITS < STEP_W) ? (STEP_W - PHASE_BITS) : 0;
    localparam logic [STEP_W-1:0] PHASE_MASK = ~((STEP_W'(1) << PHASE_CLR) - STEP_W'(1));

    // Quarter-wave table holds entries 0 to SINE_Q inclusive.
    localparam int SINE_Q     = 1 << (SINE_ADDR_BITS - 2);
    localparam int SINE_IDX_W = SINE_ADDR_BITS - 1;

    // Amplitude range check and rounding.
    localparam logic [31:0] AMP_ONE = 32'd1 << AMP_FRAC_BITS;
    localparam logic [AMP_ACC_W-1:0] AMP_ROUND = AMP_ACC_W'(1) << (AMP_FRAC_BITS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME   = 2'd3;

    // Waveform shape codes; the unused codes are silent.
    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE,
        SHAPE_SQUARE,
        SHAPE_SAW,
        SHAPE_TRI,
        SHAPE_SILENT
    } shape_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PHASE,
        ST_WAVE_SEL,
        ST_WAVE_SCALE,
        ST_AMP_LOAD,
        ST_AMP,
        ST_DONE
    } osc_state_t;

    // Stage enables of the waveform generator.
    typedef struct packed {
        logic sel_en;
        logic scale_en;
    } wave_ctrl_t;

    typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_Q];

    // Builds the quarter-wave sine magnitudes with a Taylor series in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] s;
        int          j;
        int          n;
        for (j = 0; j <= SINE_Q; j++) begin
            if (j == 0) begin
                rom[j] = '0;
            end
            else if (j == SINE_Q) begin
                rom[j] = MAG_W'(FULL_SCALE);
            end
            else begin
                x = (64'(j) * PI_HALF_Q30 + 64'(SINE_Q / 2)) / SINE_Q;
                s = x;
                t = x;
                for (n = 1; n <= 6; n++) begin
                    t = (t * x) >> 30;
                    t = (t * x) >> 30;
                    case (n)
                        1:       t = t / 6;
                        2:       t = t / 20;
                        3:       t = t / 42;
                        4:       t = t / 72;
                        5:       t = t / 110;
                        default: t = t / 156;
                    endcase
                    if ((n % 2) == 1) begin
                        s = s - t;
                    end
                    else begin
                        s = s + t;
                    end
                end
                if (s > (64'd1 << 30)) begin
                    s = 64'd1 << 30;
                end
                rom[j] = MAG_W'((s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30);
            end
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/nwo_in_if.sv @@
// Request channel of the note waveform oscillator: frame number and amplitude.
// Depends on nwo_pkg for the field widths.
interface nwo_in_if;
    import nwo_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FRAME_W-1:0]         frame_number;
    logic signed [AMP_W-1:0]    amplitude;

    modport source (output valid, output frame_number, output amplitude, input ready);
    modport sink   (input valid, input frame_number, input amplitude, output ready);
endinterface

@@ rtl/nwo_out_if.sv @@
// Result channel of the note waveform oscillator: sample, error and finished flags.
// Depends on nwo_pkg for the field widths.
interface nwo_out_if;
    import nwo_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       amp_error;
    logic                       finished;

    modport source (output valid, output sample, output amp_error, output finished,
                    input ready);
    modport sink   (input valid, input sample, input amp_error, input finished,
                    output ready);
endinterface

@@ rtl/nwo_phase_mult.sv @@
// Bit-serial phase multiplier: low bits of frame offset times phase step.
// One multiplier bit per cycle; depends on nwo_pkg.
module nwo_phase_mult (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nwo_pkg::FRAME_W-1:0]   multiplier,
    input  logic [nwo_pkg::STEP_W-1:0]    multiplicand,
    output logic                          done,
    output logic [nwo_pkg::STEP_W-1:0]    phase
);
    import nwo_pkg::*;

    localparam int CNT_W = $clog2(FRAME_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STEP_W-1:0]   acc_reg, acc_next;
    logic [STEP_W-1:0]   mcand_reg, mcand_next;
    logic [FRAME_W-1:0]  mplier_reg, mplier_next;
    logic                last_bit;

    // One shift-add step per cycle, least significant multiplier bit first.
    always_comb
    begin
        last_bit    = (cnt_reg == CNT_W'(FRAME_W - 1));
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = multiplicand;
            mplier_next = multiplier;
        end
        else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (last_bit) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done  = done_reg;
    assign phase = acc_reg & PHASE_MASK;

endmodule

@@ rtl/nwo_wave_gen.sv @@
// Waveform generator: turns a Q0.32 phase into an unscaled Q1.15 sample in two
// registered stages (shape select, then table read or scaling). Depends on nwo_pkg.
module nwo_wave_gen (
    input  logic                              clk,
    input  nwo_pkg::wave_ctrl_t               ctrl,
    input  logic [nwo_pkg::SHAPE_W-1:0]       shape,
    input  logic [nwo_pkg::STEP_W-1:0]        phase,
    output logic signed [nwo_pkg::SAMPLE_W-1:0] raw
);
    import nwo_pkg::*;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_FULL,
        SRC_ROM,
        SRC_RAMP,
        SRC_SAW
    } src_t;

    localparam logic [STEP_W-1:0] PH_QUARTER = STEP_W'(1) << (STEP_W - 2);
    localparam logic [STEP_W-1:0] PH_HALF    = STEP_W'(1) << (STEP_W - 1);
    localparam logic [STEP_W-1:0] PH_3QUART  = PH_HALF | PH_QUARTER;
    localparam int PROD_W = STEP_W + 16;

    src_t                       src_reg, src_next;
    logic                       neg_reg, neg_next;
    logic [STEP_W-1:0]          mag_reg, mag_next;
    logic [SINE_IDX_W-1:0]      idx_reg, idx_next;
    logic signed [SAMPLE_W-1:0] raw_reg, raw_next;

    logic [SINE_ADDR_BITS-1:0]  addr;
    logic [1:0]                 quad;
    logic [SINE_IDX_W-1:0]      k;
    logic [PROD_W-1:0]          prod;
    logic [MAG_W-1:0]           m;
    logic [SAMPLE_W-1:0]        m16;

    // First stage: pick the source of the magnitude and its sign.
    always_comb
    begin
        addr     = phase[STEP_W-1 -: SINE_ADDR_BITS];
        quad     = addr[SINE_ADDR_BITS-1 -: 2];
        k        = {1'b0, addr[SINE_ADDR_BITS-3:0]};
        src_next = SRC_ZERO;
        neg_next = 1'b0;
        mag_next = phase;
        idx_next = k;
        case (shape)
            SHAPE_SINE:
            begin
                src_next = SRC_ROM;
                neg_next = quad[1];
                idx_next = quad[0] ? (SINE_IDX_W'(SINE_Q) - k) : k;
            end
            SHAPE_SQUARE:
            begin
                src_next = phase[STEP_W-1] ? SRC_FULL : SRC_ZERO;
            end
            SHAPE_SAW:
            begin
                src_next = SRC_SAW;
            end
            SHAPE_TRI:
            begin
                src_next = SRC_RAMP;
                if (phase <= PH_QUARTER) begin
                    mag_next = phase;
                end
                else if (phase <= PH_HALF) begin
                    mag_next = PH_HALF - phase;
                end
                else if (phase <= PH_3QUART) begin
                    neg_next = 1'b1;
                    mag_next = phase - PH_HALF;
                end
                else begin
                    neg_next = 1'b1;
                    mag_next = STEP_W'(0) - phase;
                end
            end
            default:
            begin
                src_next = SRC_ZERO;
            end
        endcase
    end

    // Second stage: table read or round(32767 * mag / 2^shift), then the sign.
    always_comb
    begin
        prod = {1'b0, mag_reg, 15'd0} - PROD_W'(mag_reg);
        case (src_reg)
            SRC_FULL: m = MAG_W'(FULL_SCALE);
            SRC_ROM:  m = SINE_ROM[idx_reg];
            SRC_RAMP: m = MAG_W'((prod + (PROD_W'(1) << 29)) >> 30);
            SRC_SAW:  m = MAG_W'((prod + (PROD_W'(1) << 32)) >> 33);
            default:  m = '0;
        endcase
        m16      = {1'b0, m};
        raw_next = neg_reg ? $signed(SAMPLE_W'(0) - m16) : $signed(m16);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sel_en) begin
            src_reg <= src_next;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
            idx_reg <= idx_next;
        end
        if (ctrl.scale_en) begin
            raw_reg <= raw_next;
        end
    end

    assign raw = raw_reg;

endmodule

@@ rtl/nwo_amp_mult.sv @@
// Bit-serial amplitude multiplier with round to nearest on the Q16 gain.
// One sample magnitude bit per cycle; depends on nwo_pkg.
module nwo_amp_mult (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [nwo_pkg::AMP_MAG_W-1:0]   gain,
    input  logic [nwo_pkg::MAG_W-1:0]       mag,
    output logic                            done,
    output logic [nwo_pkg::SAMPLE_W-1:0]    product
);
    import nwo_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [AMP_ACC_W-1:0]  acc_reg, acc_next;
    logic [AMP_ACC_W-1:0]  mcand_reg, mcand_next;
    logic [MAG_W-1:0]      mplier_reg, mplier_next;
    logic [AMP_ACC_W-1:0]  rounded;

    // Shift-add over the magnitude bits, least significant first.
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = AMP_ACC_W'(gain);
            mplier_next = mag;
        end
        else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // Round half up and drop the gain fraction.
    assign rounded = acc_reg + AMP_ROUND;
    assign product = SAMPLE_W'(rounded >> AMP_FRAC_BITS);
    assign done    = done_reg;

endmodule

@@ rtl/note_waveform_oscillator_top.sv @@
// Note waveform oscillator top level: sequencer, configuration and result register.
// A finished, early or bad-gain request goes from the check straight to the result;
// any other runs the bit-serial phase multiply, the two wave stages and the bit-serial
// amplitude multiply first. One request is in flight at a time, and the next request
// can be taken in the cycle after the result is loaded.
// Reset clears the configuration registers, the done flag and the last sample.
// Depends on nwo_pkg, nwo_in_if, nwo_out_if, nwo_phase_mult, nwo_wave_gen, nwo_amp_mult.
module note_waveform_oscillator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    nwo_in_if.sink                            in_ch,
    nwo_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [nwo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nwo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import nwo_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] DONE_HI = SAMPLE_W'(DONE_WINDOW);
    localparam logic signed [SAMPLE_W-1:0] DONE_LO = -DONE_HI;

    osc_state_t state_reg, state_next;

    // Configuration registers.
    logic [STEP_W-1:0]           phase_step_reg;
    logic [SHAPE_W-1:0]          wave_shape_reg;
    logic [FRAME_W-1:0]          start_frame_reg;
    logic [FRAME_W-1:0]          end_frame_reg;

    // Note state and the request being worked on.
    logic                        note_done_reg, note_done_next;
    logic signed [SAMPLE_W-1:0]  last_raw_reg;
    logic [FRAME_W-1:0]          frame_reg;
    logic signed [AMP_W-1:0]     amp_reg;
    logic                        neg_reg;
    logic signed [SAMPLE_W-1:0]  res_sample_reg;
    logic                        res_err_reg;

    // Result register.
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_sample_reg;
    logic                        out_err_reg;
    logic                        out_fin_reg;

    // Sequencer strobes and datapath links.
    logic                        in_ready;
    logic                        in_take;
    logic                        phase_start;
    logic                        phase_done;
    logic [STEP_W-1:0]           phase;
    wave_ctrl_t                  wave_ctrl;
    logic signed [SAMPLE_W-1:0]  raw;
    logic [SAMPLE_W-1:0]         raw_abs;
    logic                        amp_start;
    logic                        amp_done;
    logic [SAMPLE_W-1:0]         amp_product;
    logic                        out_load;
    logic                        done_hit;
    logic                        early_out;
    logic                        amp_bad;
    logic [FRAME_W-1:0]          frame_offset;

    // Finish test and request screening.
    always_comb
    begin
        done_hit       = (frame_reg >= end_frame_reg) &&
                         (last_raw_reg >= DONE_LO) && (last_raw_reg <= DONE_HI);
        note_done_next = note_done_reg | done_hit;
        early_out      = note_done_next || (frame_reg < start_frame_reg);
        amp_bad        = amp_reg[AMP_W-1] || (32'(amp_reg[AMP_MAG_W-1:0]) > AMP_ONE);
        frame_offset   = frame_reg - start_frame_reg;
        raw_abs        = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(raw)) : SAMPLE_W'(raw);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_ch.valid) state_next = ST_CHECK;
            ST_CHECK:      state_next = (early_out || amp_bad) ? ST_DONE : ST_PHASE;
            ST_PHASE:      if (phase_done) state_next = ST_WAVE_SEL;
            ST_WAVE_SEL:   state_next = ST_WAVE_SCALE;
            ST_WAVE_SCALE: state_next = ST_AMP_LOAD;
            ST_AMP_LOAD:   state_next = ST_AMP;
            ST_AMP:        if (amp_done) state_next = ST_DONE;
            ST_DONE:       if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready           = 1'b0;
        phase_start        = 1'b0;
        wave_ctrl.sel_en   = 1'b0;
        wave_ctrl.scale_en = 1'b0;
        amp_start          = 1'b0;
        out_load           = 1'b0;
        unique case (state_reg)
            ST_IDLE:       in_ready = 1'b1;
            ST_CHECK:      phase_start = !early_out && !amp_bad;
            ST_WAVE_SEL:   wave_ctrl.sel_en = 1'b1;
            ST_WAVE_SCALE: wave_ctrl.scale_en = 1'b1;
            ST_AMP_LOAD:   amp_start = 1'b1;
            ST_DONE:       out_load = !out_valid_reg || out_ch.ready;
            default:       in_ready = 1'b0;
        endcase
    end

    assign in_take     = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // Datapath units.
    nwo_phase_mult u_phase_mult (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (phase_start),
        .multiplier   (frame_offset),
        .multiplicand (phase_step_reg),
        .done         (phase_done),
        .phase        (phase)
    );

    nwo_wave_gen u_wave_gen (
        .clk   (clk),
        .ctrl  (wave_ctrl),
        .shape (wave_shape_reg),
        .phase (phase),
        .raw   (raw)
    );

    nwo_amp_mult u_amp_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (amp_start),
        .gain    (amp_reg[AMP_MAG_W-1:0]),
        .mag     (raw_abs[MAG_W-1:0]),
        .done    (amp_done),
        .product (amp_product)
    );

    // Control state, configuration and note state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            phase_step_reg  <= '0;
            wave_shape_reg  <= '0;
            start_frame_reg <= '0;
            end_frame_reg   <= '0;
            note_done_reg   <= 1'b0;
            last_raw_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PHASE_STEP:  phase_step_reg  <= STEP_W'(cfg_wdata);
                    CFG_WAVE_SHAPE:  wave_shape_reg  <= SHAPE_W'(cfg_wdata);
                    CFG_START_FRAME: start_frame_reg <= FRAME_W'(cfg_wdata);
                    CFG_END_FRAME:   end_frame_reg   <= FRAME_W'(cfg_wdata);
                    default:         phase_step_reg  <= phase_step_reg;
                endcase
            end
            if (state_reg == ST_CHECK) begin
                note_done_reg <= note_done_next;
            end
            if (amp_start) begin
                last_raw_reg <= raw;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            frame_reg <= in_ch.frame_number;
            amp_reg   <= in_ch.amplitude;
        end
        if (state_reg == ST_CHECK) begin
            res_err_reg    <= !early_out && amp_bad;
            res_sample_reg <= (!early_out && amp_bad) ? -16'sd1 : 16'sd0;
        end
        if (amp_start) begin
            neg_reg <= raw[SAMPLE_W-1];
        end
        if (amp_done && (state_reg == ST_AMP)) begin
            res_sample_reg <= neg_reg ? $signed(SAMPLE_W'(0) - amp_product)
                                      : $signed(amp_product);
        end
        if (out_load) begin
            out_sample_reg <= res_sample_reg;
            out_err_reg    <= res_err_reg;
            out_fin_reg    <= note_done_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.sample    = out_sample_reg;
    assign out_ch.amp_error = out_err_reg;
    assign out_ch.finished  = out_fin_reg;

    // A finished note stays finished until reset.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        note_done_reg |=> note_done_reg)
        else $error("note done flag cleared");

    // A finished note gives silence and no gain error.
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.finished) |-> (out_ch.sample == 16'sd0 && !out_ch.amp_error))
        else $error("finished note gave a nonzero sample");

    // A gain error result carries the sample minus one.
    a_err_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.amp_error) |-> (out_ch.sample == -16'sd1))
        else $error("gain error without sample of minus one");

    // The phase multiplier finishes only while the sequencer waits for it.
    a_phase_done: assert property (@(posedge clk) disable iff (!rst_n)
        phase_done |-> (state_reg == ST_PHASE))
        else $error("phase multiply finished outside its state");

endmodule

@@ bench/tb_note_waveform_oscillator_top.sv @@
// Self-checking bench for note_waveform_oscillator_top: directed and random requests,
// a bit-exact sample predictor, random idling on both channels and a stall watchdog.
// Depends on nwo_pkg, nwo_in_if, nwo_out_if and the oscillator RTL.
module tb_note_waveform_oscillator_top;
    import nwo_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [FRAME_W-1:0] FRAME_TOP  = '1;
    localparam logic [FRAME_W-1:0] FRAME_SAFE = FRAME_TOP - 1'b1;

    localparam logic signed [AMP_W-1:0] GAIN_UNITY  = 18'sd65536;
    localparam logic signed [AMP_W-1:0] GAIN_TOP    = 18'sh1FFFF;
    localparam logic signed [AMP_W-1:0] GAIN_BOTTOM = 18'sh20000;

    // Shape codes past the silent one; the block treats them as silent.
    localparam logic [SHAPE_W-1:0] SHAPE_SPARE_LO = 3'd5;
    localparam logic [SHAPE_W-1:0] SHAPE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [FRAME_W-1:0]      frame;
        logic signed [AMP_W-1:0] gain;
    } note_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       amp_error;
        logic                       finished;
    } note_res_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    nwo_in_if  req_ch ();
    nwo_out_if res_ch ();

    note_waveform_oscillator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Requests waiting to be sent and samples waiting to come back.
    note_req_t pending_reqs[$];
    note_res_t expected_samples[$];

    logic req_taken = 1'b0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;
    int   results_seen = 0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_request = 0;
    int   hold_seen = 0;
    bit   quiet_tail = 1'b0;

    // Predictor copy of the registers and the note state.
    logic [STEP_W-1:0]  model_step  = '0;
    logic [SHAPE_W-1:0] model_shape = '0;
    logic [FRAME_W-1:0] model_start = '0;
    logic [FRAME_W-1:0] model_end   = '0;
    bit                 model_done  = 1'b0;
    int                 model_last  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Full-scale rounding of a magnitude: round(32767 * mag / 2^shift), halves up.
    function automatic longint scale_full(logic [63:0] mag, int shift);
        return longint'((mag * 64'(FULL_SCALE) + (64'd1 << (shift - 1))) >> shift);
    endfunction

    // Quarter-wave sine magnitude from a Taylor series in Q30.
    function automatic longint sine_quarter_mag(int unsigned j);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        int          n;
        if (j == 0)
        begin
            return 0;
        end
        if (j >= SINE_Q)
        begin
            return longint'(FULL_SCALE);
        end
        x = (64'(j) * PI_HALF_Q30 + 64'(SINE_Q / 2)) / 64'(SINE_Q);
        acc = x;
        term = x;
        for (n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        if (acc > (64'd1 << 30))
        begin
            acc = 64'd1 << 30;
        end
        return scale_full(acc, 30);
    endfunction

    // Unscaled Q1.15 waveform value for one phase under the current shape.
    function automatic longint note_wave_value(logic [31:0] phase);
        logic [SINE_ADDR_BITS-1:0] addr;
        int unsigned               j;
        longint                    mag;
        case (model_shape)
            SHAPE_SINE:
            begin
                addr = phase[31 -: SINE_ADDR_BITS];
                j = 32'(addr[SINE_ADDR_BITS-3:0]);
                if (addr[SINE_ADDR_BITS-2])
                begin
                    j = SINE_Q - j;
                end
                mag = sine_quarter_mag(j);
                return addr[SINE_ADDR_BITS-1] ? -mag : mag;
            end
            SHAPE_SQUARE:
            begin
                return phase[31] ? longint'(FULL_SCALE) : 0;
            end
            SHAPE_SAW:
            begin
                return scale_full(64'(phase), 33);
            end
            SHAPE_TRI:
            begin
                if (phase <= 32'h4000_0000)
                begin
                    return scale_full(64'(phase), 30);
                end
                if (phase <= 32'h8000_0000)
                begin
                    return scale_full(64'(32'h8000_0000 - phase), 30);
                end
                if (phase <= 32'hC000_0000)
                begin
                    return -scale_full(64'(phase - 32'h8000_0000), 30);
                end
                return -scale_full(64'h1_0000_0000 - 64'(phase), 30);
            end
            default:
            begin
                return 0;
            end
        endcase
    endfunction

    // Expected result of one request; advances the done flag and last sample.
    function automatic note_res_t next_note_sample(logic [FRAME_W-1:0] frame,
                                                   logic signed [AMP_W-1:0] gain);
        note_res_t   res;
        logic [63:0] span;
        logic [31:0] phase;
        longint      gain_l;
        longint      raw;
        longint      mag;
        longint      prod;
        res = '0;
        gain_l = longint'(gain);
        if (frame >= model_end && model_last >= -DONE_WINDOW && model_last <= DONE_WINDOW)
        begin
            model_done = 1'b1;
        end
        if (!model_done && frame >= model_start)
        begin
            if (gain_l < 0 || gain_l > (longint'(1) << AMP_FRAC_BITS))
            begin
                res.sample = '1;
                res.amp_error = 1'b1;
            end
            else
            begin
                span = 64'(frame) - 64'(model_start);
                phase = 32'(span * 64'(model_step)) & PHASE_MASK;
                raw = note_wave_value(phase);
                model_last = int'(raw);
                mag = (raw < 0) ? -raw : raw;
                prod = (gain_l * mag + (longint'(1) << (AMP_FRAC_BITS - 1))) >>> AMP_FRAC_BITS;
                res.sample = SAMPLE_W'((raw < 0) ? -prod : prod);
            end
        end
        res.finished = model_done;
        return res;
    endfunction

    // Request driver: holds an offered request until it is taken, idles in bursts.
    always @(negedge clk)
    begin
        if (req_taken)
        begin
            void'(pending_reqs.pop_front());
        end
        if (send_gap > 0)
        begin
            send_gap--;
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken)
        begin
            // The offered request is still waiting; leave it in place.
        end
        else if (pending_reqs.size() == 0)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            send_gap = $urandom_range(0, 6);
            req_ch.valid <= 1'b0;
        end
        else
        begin
            req_ch.valid        <= 1'b1;
            req_ch.frame_number <= pending_reqs[0].frame;
            req_ch.amplitude    <= pending_reqs[0].gain;
        end
    end

    // Result receiver: random stall bursts plus one long hold-off when the stimulus asks for it.
    always @(negedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: tracks register writes, predicts on each request and checks results.
    always @(posedge clk)
    begin : monitor
        note_res_t want;
        logic      req_fire;
        logic      res_fire;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        res_fire = rst_n && res_ch.valid && res_ch.ready;
        req_taken <= req_fire;

        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:  model_step  = cfg_wdata[STEP_W-1:0];
                CFG_WAVE_SHAPE:  model_shape = cfg_wdata[SHAPE_W-1:0];
                CFG_START_FRAME: model_start = cfg_wdata[FRAME_W-1:0];
                CFG_END_FRAME:   model_end   = cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end

        if (req_fire)
        begin
            expected_samples.push_back(next_note_sample(req_ch.frame_number,
                                                        req_ch.amplitude));
        end

        if (res_fire)
        begin
            results_seen++;
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with nothing expected, sample %0d",
                                          results_seen, res_ch.sample));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (res_ch.sample !== want.sample)
                begin
                    report_mismatch($sformatf("result %0d sample %0d, expected %0d",
                                              results_seen, res_ch.sample, want.sample));
                end
                if (res_ch.amp_error !== want.amp_error)
                begin
                    report_mismatch($sformatf("result %0d amp_error %b, expected %b",
                                              results_seen, res_ch.amp_error,
                                              want.amp_error));
                end
                if (res_ch.finished !== want.finished)
                begin
                    report_mismatch($sformatf("result %0d finished %b, expected %b",
                                              results_seen, res_ch.finished,
                                              want.finished));
                end
            end
        end

        if (!rst_n || req_fire || res_fire)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    // Writes all four note registers; only called while the block is idle.
    task automatic program_note(logic [STEP_W-1:0] step, logic [SHAPE_W-1:0] shape,
                                logic [FRAME_W-1:0] first, logic [FRAME_W-1:0] last);
        write_reg(CFG_PHASE_STEP, CFG_DATA_W'(step));
        write_reg(CFG_WAVE_SHAPE, CFG_DATA_W'(shape));
        write_reg(CFG_START_FRAME, CFG_DATA_W'(first));
        write_reg(CFG_END_FRAME, CFG_DATA_W'(last));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(logic [FRAME_W-1:0] frame, logic signed [AMP_W-1:0] gain);
        note_req_t req;
        req.frame = frame;
        req.gain = gain;
        pending_reqs.push_back(req);
    endtask

    // Waits until every request has been sent and every sample has come back.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly a walk of consecutive frames from the note start with legal gains,
    // mixed with frames before the start and fully random requests.
    task automatic queue_note_run(logic [FRAME_W-1:0] first, int count);
        logic [31:0]             offset;
        logic [31:0]             frame;
        logic signed [AMP_W-1:0] gain;
        int unsigned             pick;
        int                      i;
        offset = $urandom_range(0, 3);
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                frame = 32'(first) + offset;
                offset = offset + ((pick < 70) ? 32'd1 : 32'($urandom_range(2, 50)));
                if (pick < 76)
                begin
                    gain = AMP_W'($urandom_range(0, 65536));
                end
                else
                begin
                    gain = AMP_W'($urandom);
                end
            end
            else if (pick < 90)
            begin
                frame = $urandom_range(0, 32'(first));
                gain = AMP_W'($urandom_range(0, 65536));
            end
            else
            begin
                frame = $urandom & 32'h7FFF_FFFF;
                gain = AMP_W'($urandom);
            end
            if (frame > 32'(FRAME_SAFE))
            begin
                frame = 32'(FRAME_SAFE);
            end
            queue_item(frame[FRAME_W-1:0], gain);
        end
    endtask

    // Odd frames at a half-cycle phase step give a full-scale square sample,
    // which keeps the note sounding even past the end frame.
    task automatic queue_loud_run(int count, bit wild_gain);
        logic [31:0]             frame;
        logic signed [AMP_W-1:0] gain;
        int                      i;
        for (i = 0; i < count; i++)
        begin
            frame = ($urandom_range(0, 32'h3FFF_FFFE) << 1) | 32'd1;
            if (wild_gain && $urandom_range(0, 1) == 1)
            begin
                gain = AMP_W'($urandom);
            end
            else
            begin
                gain = AMP_W'($urandom_range(0, 65536));
            end
            queue_item(frame[FRAME_W-1:0], gain);
        end
    endtask

    // Watchdog: ends the run when nothing is accepted for too long.
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("** note_waveform_oscillator_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        logic [STEP_W-1:0]  step;
        logic [SHAPE_W-1:0] shape;
        logic [FRAME_W-1:0] first;
        logic [31:0]        frame;
        int                 p;
        int                 i;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.frame_number = '0;
        req_ch.amplitude    = '0;
        res_ch.ready        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sine: frames around the start, gain extremes and the bad-gain cases.
        program_note(32'h0A3D_70A4, SHAPE_SINE, 31'd1000, FRAME_TOP);
        queue_item(31'd0, GAIN_UNITY);
        queue_item(31'd999, GAIN_UNITY);
        queue_item(31'd1000, GAIN_UNITY);
        queue_item(31'd1001, '0);
        queue_item(31'd1002, GAIN_UNITY);
        queue_item(31'd1003, GAIN_UNITY + 1'b1);
        queue_item(31'd1004, -18'sd1);
        queue_item(31'd1005, GAIN_BOTTOM);
        queue_item(31'd1006, GAIN_TOP);
        queue_item(FRAME_SAFE, GAIN_UNITY);
        queue_item(31'd1500, 18'sd32768);
        wait_idle();

        // Square at both halves of the cycle.
        program_note(32'h8000_0000, SHAPE_SQUARE, 31'd0, FRAME_TOP);
        queue_item(31'd0, GAIN_UNITY);
        queue_item(31'd1, GAIN_UNITY);
        wait_idle();

        // Sawtooth at a quarter and three quarters of the cycle.
        program_note(32'h4000_0000, SHAPE_SAW, 31'd5, FRAME_TOP);
        queue_item(31'd6, GAIN_UNITY);
        queue_item(31'd8, GAIN_UNITY);
        wait_idle();

        // Triangle on each of its corner phases.
        program_note(32'h4000_0000, SHAPE_TRI, 31'd0, FRAME_TOP);
        for (i = 0; i < 4; i++)
        begin
            queue_item(FRAME_W'(i), GAIN_UNITY);
        end
        wait_idle();

        // Silent shape and an unused shape code.
        program_note(32'h1234_5678, SHAPE_SILENT, 31'd0, FRAME_TOP);
        queue_item(31'd12345, GAIN_UNITY);
        wait_idle();
        program_note(32'h1234_5678, SHAPE_SPARE_HI, 31'd0, FRAME_TOP);
        queue_item(31'd777, GAIN_UNITY);
        wait_idle();

        // Start at the last frame: every request lies before the note.
        program_note('1, SHAPE_SINE, FRAME_TOP, FRAME_TOP);
        queue_item(31'd0, GAIN_UNITY);
        queue_item(FRAME_SAFE, GAIN_UNITY);
        wait_idle();

        // Random notes; the end frame stays out of reach so the note keeps sounding.
        for (p = 0; p < 8; p++)
        begin
            if (p == 0)
            begin
                step = '0;
            end
            else if (p == 1)
            begin
                step = '1;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                step = $urandom_range(1, 32'h00FF_FFFF);
            end
            else
            begin
                step = $urandom;
            end
            if (p < 7)
            begin
                shape = SHAPE_W'(p);
            end
            else
            begin
                shape = SHAPE_W'($urandom_range(SHAPE_SINE, SHAPE_SPARE_HI));
            end
            first = (p == 2) ? '0 : FRAME_W'($urandom_range(0, 32'h7FFF_0000));
            program_note(step, shape, first, FRAME_TOP);
            if (p == 3)
            begin
                // Receiver holds off while the sender keeps offering requests.
                @(posedge clk);
                hold_request++;
            end
            queue_note_run(first, 40);
            wait_idle();
        end
        program_note(32'h8000_0000, SHAPE_SPARE_LO, 31'd0, FRAME_TOP);
        queue_note_run(31'd0, 5);
        wait_idle();

        // Loud square, then the end frame at zero while the last sample stays loud.
        program_note(32'h8000_0000, SHAPE_SQUARE, 31'd0, FRAME_TOP);
        queue_loud_run(10, 1'b0);
        wait_idle();
        program_note(32'h8000_0000, SHAPE_SQUARE, 31'd0, 31'd0);
        queue_loud_run(30, 1'b1);
        wait_idle();

        // Closing note without idling: a sine past its end frame finishes at
        // the next zero crossing and stays silent afterwards.
        quiet_tail = 1'b1;
        first = FRAME_W'($urandom_range(1000, 32'h7000_0000));
        program_note(32'h0400_0000, SHAPE_SINE, first, first + 31'd100);
        for (i = 0; i < 170; i++)
        begin
            frame = 32'(first) + 32'(i);
            if ($urandom_range(0, 19) == 0)
            begin
                queue_item(frame[FRAME_W-1:0], AMP_W'($urandom));
            end
            else
            begin
                queue_item(frame[FRAME_W-1:0], AMP_W'($urandom_range(0, 65536)));
            end
        end
        queue_item(FRAME_TOP, GAIN_UNITY);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_samples.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected samples never arrived",
                                      expected_samples.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("** note_waveform_oscillator_top: PASSED **");
        end
        else
        begin
            $display("** note_waveform_oscillator_top: FAILED **");
        end
        $finish;
    end

endmodule
